[sv/bdl_pkg.sv]
// ----------------------------------------------------------------------------
// bdl_pkg
// Shared types, codes and defaults for the bounded deque list.
// ----------------------------------------------------------------------------
package bdl_pkg;

    // Default sizing, handed to the top-level parameters
    localparam int DEPTH_DEF      = 256;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed beat field widths
    localparam int OPCODE_W    = 3;
    localparam int ENTRY_W     = 32;
    localparam int POS_W       = 8;
    localparam int COUNT_OUT_W = 9;
    localparam int STATUS_W    = 2;

    // Request opcodes; the remaining code is a no-op
    localparam logic [OPCODE_W-1:0] OP_INS_HEAD = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_INS_TAIL = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_REM_HEAD = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_REM_TAIL = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_RD_HEAD  = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_RD_TAIL  = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_RD_INDEX = 3'd6;

    // Response status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [ENTRY_W-1:0]  entry_data;
        logic [POS_W-1:0]    item_position;
    } t_req;

    typedef struct packed {
        logic [ENTRY_W-1:0]     read_data;
        logic [COUNT_OUT_W-1:0] entry_count;
        logic [STATUS_W-1:0]    status;
    } t_rsp;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;  // latch the accepted request beat
        logic execute;  // check, access the store, update pointers
    } t_cmd;

endpackage

[sv/bdl_req_if.sv]
// ----------------------------------------------------------------------------
// bdl_req_if
// Request channel: valid/ready handshake carrying one request beat.
// ----------------------------------------------------------------------------
interface bdl_req_if;
    import bdl_pkg::*;

    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/bdl_rsp_if.sv]
// ----------------------------------------------------------------------------
// bdl_rsp_if
// Response channel: valid/ready handshake carrying one response beat.
// ----------------------------------------------------------------------------
interface bdl_rsp_if;
    import bdl_pkg::*;

    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/bdl_ram.sv]
// ----------------------------------------------------------------------------
// bdl_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bdl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/bdl_ctrl.sv]
// ----------------------------------------------------------------------------
// bdl_ctrl
// Request sequencer: accept a beat, execute it, present the response.
// ----------------------------------------------------------------------------
module bdl_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output bdl_pkg::t_cmd o_cmd
);
    import bdl_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_RESP = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                if (i_rsp_ready) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // handshakes and commands
    assign o_req_ready   = (r_state == S_IDLE);
    assign o_rsp_valid   = (r_state == S_RESP);
    assign o_cmd.capture = (r_state == S_IDLE) && i_req_valid;
    assign o_cmd.execute = (r_state == S_EXEC);

endmodule

[sv/bdl_dpath.sv]
// ----------------------------------------------------------------------------
// bdl_dpath
// Circular-buffer datapath: head pointer, count, checks and entry store.
// ----------------------------------------------------------------------------
module bdl_dpath #(
    parameter int DEPTH      = bdl_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = bdl_pkg::DATA_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bdl_pkg::t_cmd i_cmd,
    input  bdl_pkg::t_req i_req,
    output bdl_pkg::t_rsp o_rsp
);
    import bdl_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = (CW > POS_W) ? CW : POS_W;

    // request register
    t_req r_req;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req;
        end
    end

    logic [AW-1:0]       r_head;
    logic [CW-1:0]       r_count;
    logic [STATUS_W-1:0] r_status;
    logic                r_rd_hit;

    logic                full;
    logic                empty;
    logic                pos_bad;
    logic [SW-1:0]       offset;
    logic [SW:0]         slot_sum;
    logic [AW-1:0]       slot;
    logic [AW-1:0]       head_dec;

    logic [AW-1:0]       n_head;
    logic [CW-1:0]       n_count;
    logic [STATUS_W-1:0] n_status;
    logic                do_wr;
    logic                do_rd;
    logic [AW-1:0]       addr;

    logic [DATA_WIDTH-1:0] ram_rdata;

    assign full    = (r_count == CW'(DEPTH));
    assign empty   = (r_count == '0);
    assign pos_bad = (SW'(r_req.item_position) >= SW'(r_count));

    // position from head for this opcode
    always_comb begin
        unique case (r_req.opcode)
            OP_INS_TAIL: offset = SW'(r_count);
            OP_REM_HEAD: offset = SW'(1);
            OP_RD_TAIL:  offset = SW'(r_count - CW'(1));
            OP_RD_INDEX: offset = SW'(r_req.item_position);
            default:     offset = '0;
        endcase
    end

    // head + offset modulo DEPTH; sum stays below twice the depth whenever the slot is used
    assign slot_sum = (SW+1)'(r_head) + (SW+1)'(offset);
    assign slot     = (slot_sum >= (SW+1)'(DEPTH)) ? AW'(slot_sum - (SW+1)'(DEPTH))
                                                   : AW'(slot_sum);
    assign head_dec = (r_head == '0) ? AW'(DEPTH - 1) : (r_head - AW'(1));

    // checks and effects of the held request
    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_status = ST_DONE;
        do_wr    = 1'b0;
        do_rd    = 1'b0;
        addr     = slot;
        unique case (r_req.opcode)
            OP_INS_HEAD: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    do_wr   = 1'b1;
                    addr    = head_dec;
                    n_head  = head_dec;
                    n_count = r_count + CW'(1);
                end
            end
            OP_INS_TAIL: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    do_wr   = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            OP_REM_HEAD: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_head  = slot;
                    n_count = r_count - CW'(1);
                end
            end
            OP_REM_TAIL: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_count = r_count - CW'(1);
                end
            end
            OP_RD_HEAD, OP_RD_TAIL: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    do_rd = 1'b1;
                end
            end
            OP_RD_INDEX: begin
                if (pos_bad) begin
                    n_status = ST_RANGE;
                end else begin
                    do_rd = 1'b1;
                end
            end
            default: begin
                // unused opcode: no-op
            end
        endcase
    end

    // pointer and count state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_cmd.execute) begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // response fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_status <= n_status;
            r_rd_hit <= do_rd;
        end
    end

    bdl_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.execute && do_wr),
        .i_waddr (addr),
        .i_wdata (DATA_WIDTH'(r_req.entry_data)),
        .i_re    (i_cmd.execute && do_rd),
        .i_raddr (addr),
        .o_rdata (ram_rdata)
    );

    assign o_rsp.read_data   = r_rd_hit ? ENTRY_W'(ram_rdata) : '0;
    assign o_rsp.entry_count = COUNT_OUT_W'(r_count);
    assign o_rsp.status      = r_status;

endmodule

[sv/bounded_deque_list.sv]
// ----------------------------------------------------------------------------
// bounded_deque_list
// Bounded double-ended list held in a circular buffer with a head pointer.
// ----------------------------------------------------------------------------
// Each request beat inserts or removes at the head or tail, or reads the head,
// the tail or the entry at a position counted from the head, and returns one
// response beat with read data, the count after the request and a status
// (done, full, empty, position out of range); a rejected request changes
// nothing. A request passes through the accept state, an execute state that
// does at most one entry store access and the pointer update, and the state in
// which the response beat is presented; the next request is accepted the cycle
// after the response beat is taken. The entry store needs no clearing after
// reset.
module bounded_deque_list #(
    parameter int DEPTH      = bdl_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = bdl_pkg::DATA_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bdl_req_if.sink   i_req,
    bdl_rsp_if.source o_rsp
);
    import bdl_pkg::*;

    t_cmd cmd;
    logic req_ready;
    logic rsp_valid;

    bdl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    bdl_dpath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (i_req.data),
        .o_rsp   (o_rsp.data)
    );

    assign i_req.ready = req_ready;
    assign o_rsp.valid = rsp_valid;

endmodule

[tb/bounded_deque_list_tb.sv]
// ----------------------------------------------------------------------------
// bounded_deque_list_tb
// Self-checking testbench for the bounded deque list.
// ----------------------------------------------------------------------------
// Request beats go in through the request channel, and a scoreboard predicts
// each response from its own copy of the circular buffer, the head pointer and
// the count. Directed tests hit the empty and full edges and every opcode.
// Random tests then fill, drain and churn the list with random data and
// positions. Both channels idle at random.
// ----------------------------------------------------------------------------
module bounded_deque_list_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bdl_pkg::*;

    localparam int LIST_DEPTH     = DEPTH_DEF;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 10;

    // Code with no operation behind it
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 3'd7;

    typedef enum int { MIX_GROW, MIX_SHRINK, MIX_EVEN } t_mix;

    logic i_clk;
    logic i_rst_n;

    bdl_req_if req_if ();
    bdl_rsp_if rsp_if ();

    bounded_deque_list dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Predicted deque contents
    logic [ENTRY_W-1:0]     model_store [LIST_DEPTH];
    logic [POS_W-1:0]       model_head;
    logic [COUNT_OUT_W-1:0] model_count;

    t_rsp expected_rsp_q [$];
    int   error_count;
    int   idle_cycles;
    int   req_quiet;
    int   rsp_quiet;
    int   rsp_stall;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Gap length: mostly none or short, a few long, with stretches of none
    function automatic int pick_gap(ref int quiet);
        int r;
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            quiet = $urandom_range(40, 200);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Apply one request to the deque copy and return its response
    function automatic t_rsp deque_predict(t_req r);
        t_rsp             rsp;
        logic [POS_W-1:0] slot;
        rsp = '0;
        rsp.status = ST_DONE;
        case (r.opcode)
            OP_INS_HEAD: begin
                if (model_count >= LIST_DEPTH) begin
                    rsp.status = ST_FULL;
                end else begin
                    model_head = model_head - 1'b1;
                    model_store[model_head] = r.entry_data;
                    model_count++;
                end
            end
            OP_INS_TAIL: begin
                if (model_count >= LIST_DEPTH) begin
                    rsp.status = ST_FULL;
                end else begin
                    slot = model_head + POS_W'(model_count);
                    model_store[slot] = r.entry_data;
                    model_count++;
                end
            end
            OP_REM_HEAD: begin
                if (model_count == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    model_head = model_head + 1'b1;
                    model_count--;
                end
            end
            OP_REM_TAIL: begin
                if (model_count == 0) rsp.status = ST_EMPTY;
                else model_count--;
            end
            OP_RD_HEAD: begin
                if (model_count == 0) rsp.status = ST_EMPTY;
                else rsp.read_data = model_store[model_head];
            end
            OP_RD_TAIL: begin
                if (model_count == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    slot = model_head + POS_W'(model_count - 1'b1);
                    rsp.read_data = model_store[slot];
                end
            end
            OP_RD_INDEX: begin
                if ({1'b0, r.item_position} >= model_count) begin
                    rsp.status = ST_RANGE;
                end else begin
                    slot = model_head + r.item_position;
                    rsp.read_data = model_store[slot];
                end
            end
            default: ;
        endcase
        rsp.entry_count = model_count;
        return rsp;
    endfunction

    function automatic t_req make_req(logic [OPCODE_W-1:0] op,
                                      logic [ENTRY_W-1:0] d = '0,
                                      logic [POS_W-1:0] p = '0);
        t_req r;
        r.opcode        = op;
        r.entry_data    = d;
        r.item_position = p;
        return r;
    endfunction

    // Random request; the mix steers the list toward full, empty or neither
    function automatic t_req random_request(t_mix mix);
        t_req r;
        int   pick;
        int   ins_pct;
        int   rem_pct;
        int   sel;
        ins_pct = (mix == MIX_GROW) ? 70 : (mix == MIX_SHRINK) ? 10 : 35;
        rem_pct = (mix == MIX_GROW) ? 10 : (mix == MIX_SHRINK) ? 70 : 35;
        pick = $urandom_range(0, 99);
        if (pick < ins_pct) begin
            r.opcode = (pick % 2) ? OP_INS_TAIL : OP_INS_HEAD;
        end else if (pick < ins_pct + rem_pct) begin
            r.opcode = (pick % 2) ? OP_REM_TAIL : OP_REM_HEAD;
        end else begin
            sel = $urandom_range(0, 19);
            if (sel < 5)       r.opcode = OP_RD_HEAD;
            else if (sel < 10) r.opcode = OP_RD_TAIL;
            else if (sel < 19) r.opcode = OP_RD_INDEX;
            else               r.opcode = OP_UNUSED;
        end
        sel = $urandom_range(0, 9);
        if (sel == 0)      r.entry_data = '0;
        else if (sel == 1) r.entry_data = '1;
        else               r.entry_data = $urandom;
        // mostly positions inside the list, some anywhere
        if (model_count != 0 && $urandom_range(0, 3) != 0)
            r.item_position = POS_W'($urandom_range(0, model_count - 1));
        else
            r.item_position = POS_W'($urandom_range(0, 255));
        return r;
    endfunction

    // Send one request beat and record its expected response on acceptance
    task automatic send_request(t_req r);
        int gap;
        gap = pick_gap(req_quiet);
        repeat (gap) begin
            @(negedge i_clk);
            req_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        do @(posedge i_clk); while (!req_if.ready);
        expected_rsp_q.push_back(deque_predict(r));
    endtask

    // Hold off requests until every response is back
    task automatic wait_for_results();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (expected_rsp_q.size() != 0) @(posedge i_clk);
    endtask

    // Every remove and read on an empty list, plus the unused code
    task automatic test_empty_list();
        send_request(make_req(OP_REM_HEAD));
        send_request(make_req(OP_REM_TAIL));
        send_request(make_req(OP_RD_HEAD));
        send_request(make_req(OP_RD_TAIL));
        send_request(make_req(OP_RD_INDEX, '0, 8'd0));
        send_request(make_req(OP_RD_INDEX, '1, 8'hFF));
        send_request(make_req(OP_UNUSED, '1, 8'hFF));
    endtask

    // Extreme data, every opcode, index just past the tail
    task automatic test_basic_ops();
        send_request(make_req(OP_INS_TAIL, 32'h0000_0000));
        send_request(make_req(OP_INS_HEAD, 32'hFFFF_FFFF));
        send_request(make_req(OP_INS_TAIL, 32'hA5A5_5A5A, 8'hFF));
        send_request(make_req(OP_RD_HEAD));
        send_request(make_req(OP_RD_TAIL));
        send_request(make_req(OP_RD_INDEX, '0, 8'd0));
        send_request(make_req(OP_RD_INDEX, '0, 8'd1));
        send_request(make_req(OP_RD_INDEX, '0, 8'd2));
        send_request(make_req(OP_RD_INDEX, '0, 8'd3));
        send_request(make_req(OP_UNUSED, 32'h1234_5678, 8'd1));
        send_request(make_req(OP_REM_HEAD));
        send_request(make_req(OP_REM_TAIL));
        send_request(make_req(OP_RD_HEAD));
        send_request(make_req(OP_REM_HEAD));
    endtask

    // Grow to full, then poke at the full edge
    task automatic test_fill_to_full();
        while (model_count < LIST_DEPTH) send_request(random_request(MIX_GROW));
        send_request(make_req(OP_INS_HEAD, $urandom));
        send_request(make_req(OP_INS_TAIL, $urandom));
        send_request(make_req(OP_RD_INDEX, '0, 8'hFF));
        send_request(make_req(OP_RD_HEAD));
        send_request(make_req(OP_RD_TAIL));
        send_request(make_req(OP_REM_HEAD));
        send_request(make_req(OP_INS_TAIL, $urandom));
        send_request(make_req(OP_REM_TAIL));
        send_request(make_req(OP_INS_HEAD, $urandom));
        send_request(make_req(OP_INS_HEAD, $urandom));
    endtask

    // Shrink to empty, then check the empty edge again
    task automatic test_drain_to_empty();
        while (model_count != 0) send_request(random_request(MIX_SHRINK));
        send_request(make_req(OP_REM_TAIL));
        send_request(make_req(OP_RD_TAIL));
        send_request(make_req(OP_RD_INDEX, '0, 8'd0));
    endtask

    // Phases of growth, shrinkage and churn of random length
    task automatic test_random_churn(int n_items);
        int   sent;
        int   len;
        t_mix mix;
        sent = 0;
        while (sent < n_items) begin
            mix = t_mix'($urandom_range(0, 2));
            len = $urandom_range(20, 150);
            repeat (len) send_request(random_request(mix));
            sent += len;
        end
    endtask

    // Response side: random stalls on ready
    always @(negedge i_clk) begin
        if (rsp_stall > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_stall--;
        end else begin
            rsp_if.ready <= 1'b1;
            rsp_stall = pick_gap(rsp_quiet);
        end
    end

    // Scoreboard: compare each response beat with the oldest prediction
    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_rsp_q.size() == 0) begin
                $error("response beat with no request outstanding");
                error_count++;
            end else begin
                exp_rsp = expected_rsp_q.pop_front();
                if (rsp_if.data.read_data !== exp_rsp.read_data) begin
                    $error("read_data: expected %h, got %h",
                           exp_rsp.read_data, rsp_if.data.read_data);
                    error_count++;
                end
                if (rsp_if.data.entry_count !== exp_rsp.entry_count) begin
                    $error("entry_count: expected %0d, got %0d",
                           exp_rsp.entry_count, rsp_if.data.entry_count);
                    error_count++;
                end
                if (rsp_if.data.status !== exp_rsp.status) begin
                    $error("status: expected %0d, got %0d",
                           exp_rsp.status, rsp_if.data.status);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no beat moving on either channel
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Test sequence
    initial begin
        i_rst_n      = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        rsp_if.ready = 1'b0;
        model_head   = '0;
        model_count  = '0;
        error_count  = 0;
        idle_cycles  = 0;
        req_quiet    = 0;
        rsp_quiet    = 0;
        rsp_stall    = 0;
        foreach (model_store[i]) model_store[i] = '0;

        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_list();
        test_basic_ops();
        test_fill_to_full();
        wait_for_results();
        test_drain_to_empty();
        test_random_churn(1000);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

endmodule
